/* design/ccrp_pkg.sv */
// ----------------------------------------------------------------------------
// ccrp_pkg
// Shared types, codes and ratio compare helpers for the rudder positioner.
// ----------------------------------------------------------------------------
package ccrp_pkg;

   localparam int CountWidth = 16;
   localparam int ProdWidth  = CountWidth + 5;
   localparam int SpeedWidth = 9;
   localparam int DriveWidth = 10;
   localparam int ColorWidth = 3;

   localparam logic [SpeedWidth-1:0] SpeedLimit = 9'd400;
   localparam logic [SpeedWidth-1:0] SlowReset  = 9'd200;
   localparam logic [SpeedWidth-1:0] FastReset  = 9'd400;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [ColorWidth-1:0] color_type;
   typedef logic [SpeedWidth-1:0] speed_type;
   typedef logic signed [DriveWidth-1:0] drive_type;

   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_CENTER  = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic {
      CSR_SLOW_SPEED = 1'b0,
      CSR_FAST_SPEED = 1'b1
   } csr_index_type;

   localparam logic [7:0] CmdCenter   = 8'h63;
   localparam logic [7:0] CmdColorLow = 8'h31;
   localparam logic [7:0] CmdColorHigh = 8'h37;

   localparam color_type ColorCenter = 3'd4;

   // c/x >= p/q
   function automatic logic ratio_ge(input count_type c, input count_type x,
                                     input logic [4:0] p, input logic [4:0] q);
      logic [ProdWidth-1:0] lhs;
      logic [ProdWidth-1:0] rhs;
      lhs = ProdWidth'(c) * ProdWidth'(q);
      rhs = ProdWidth'(p) * ProdWidth'(x);
      if (x == '0) ratio_ge = (c != '0);
      else ratio_ge = (lhs >= rhs);
   endfunction

   // c/x > p/q
   function automatic logic ratio_gt(input count_type c, input count_type x,
                                     input logic [4:0] p, input logic [4:0] q);
      logic [ProdWidth-1:0] lhs;
      logic [ProdWidth-1:0] rhs;
      lhs = ProdWidth'(c) * ProdWidth'(q);
      rhs = ProdWidth'(p) * ProdWidth'(x);
      if (x == '0) ratio_gt = (c != '0);
      else ratio_gt = (lhs > rhs);
   endfunction

   // c/x <= p/q
   function automatic logic ratio_le(input count_type c, input count_type x,
                                     input logic [4:0] p, input logic [4:0] q);
      logic [ProdWidth-1:0] lhs;
      logic [ProdWidth-1:0] rhs;
      lhs = ProdWidth'(c) * ProdWidth'(q);
      rhs = ProdWidth'(p) * ProdWidth'(x);
      if (x == '0) ratio_le = 1'b0;
      else ratio_le = (lhs <= rhs);
   endfunction

   // c/x < p/q
   function automatic logic ratio_lt(input count_type c, input count_type x,
                                     input logic [4:0] p, input logic [4:0] q);
      logic [ProdWidth-1:0] lhs;
      logic [ProdWidth-1:0] rhs;
      lhs = ProdWidth'(c) * ProdWidth'(q);
      rhs = ProdWidth'(p) * ProdWidth'(x);
      if (x == '0) ratio_lt = 1'b0;
      else ratio_lt = (lhs < rhs);
   endfunction

endpackage

/* design/color_coded_rudder_positioner.sv */
// ----------------------------------------------------------------------------
// color_coded_rudder_positioner
// Classifies color sensor samples and drives the rudder toward a target color.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the input register is empty or the result
// is not stalled. Each item is held in an input register and then processed by
// a single pass of compare logic and the move state update, landing in the result
// register, from which it is shown and can be taken. A stalled result holds the
// item behind it, and only then the input. Configuration writes are always
// accepted.
// ----------------------------------------------------------------------------
module color_coded_rudder_positioner (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_command_byte,
   input  logic [15:0]                     req_clear_count,
   input  logic [15:0]                     req_red_count,
   input  logic [15:0]                     req_green_count,
   input  logic [15:0]                     req_blue_count,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [9:0]               rsp_motor_speed,
   output logic [2:0]                      rsp_color_code,
   output logic                            rsp_busy_res,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [8:0]                      csr_data
);

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_UP   = 2'd1,
      PHASE_DOWN = 2'd2
   } phase_type;

   ccrp_pkg::speed_type slow_speed_ff;
   ccrp_pkg::speed_type fast_speed_ff;

   logic                s1_valid_ff;
   logic [1:0]          s1_operation_ff;
   logic [7:0]          s1_command_ff;
   ccrp_pkg::count_type s1_clear_ff;
   ccrp_pkg::count_type s1_red_ff;
   ccrp_pkg::count_type s1_green_ff;
   ccrp_pkg::count_type s1_blue_ff;

   ccrp_pkg::color_type current_color_ff, current_color_in;
   ccrp_pkg::color_type target_color_ff, target_color_in;
   phase_type           phase_ff, phase_in;
   logic                slow_only_ff, slow_only_in;
   ccrp_pkg::drive_type drive_ff, drive_in;

   logic                rsp_valid_ff;
   ccrp_pkg::drive_type rsp_motor_speed_ff;
   ccrp_pkg::color_type rsp_color_code_ff;
   logic                rsp_busy_res_ff;

   logic                advance;
   logic                busy;
   ccrp_pkg::color_type sample_color;
   logic                sample_match;
   ccrp_pkg::color_type diff_up, diff_down;
   ccrp_pkg::speed_type mag_up, mag_down;
   ccrp_pkg::speed_type mag_sel_up, mag_sel_down;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_speed = rsp_motor_speed_ff;
   assign rsp_color_code  = rsp_color_code_ff;
   assign rsp_busy_res    = rsp_busy_res_ff;

   assign busy = (phase_ff != PHASE_IDLE);

   // classify: first matching rule wins
   always_comb begin
      ccrp_pkg::count_type c, r, g, b;
      c = s1_clear_ff;
      r = s1_red_ff;
      g = s1_green_ff;
      b = s1_blue_ff;
      sample_match = 1'b1;
      sample_color = '0;
      priority if (ccrp_pkg::ratio_ge(c, r, 5'd11, 5'd2)) begin
         sample_color = 3'd1;
      end else if (ccrp_pkg::ratio_ge(c, b, 5'd4, 5'd1) &&
                   ccrp_pkg::ratio_le(c, g, 5'd3, 5'd1)) begin
         sample_color = 3'd2;
      end else if (c > 16'd5500 && c <= 16'd7500 &&
                   ccrp_pkg::ratio_ge(c, r, 5'd18, 5'd5) &&
                   ccrp_pkg::ratio_le(c, r, 5'd22, 5'd5) &&
                   ccrp_pkg::ratio_gt(c, g, 5'd3, 5'd1)) begin
         sample_color = 3'd3;
      end else if (c <= 16'd3500 &&
                   ccrp_pkg::ratio_ge(c, r, 5'd5, 5'd2) &&
                   ccrp_pkg::ratio_lt(c, r, 5'd7, 5'd2)) begin
         sample_color = 3'd4;
      end else if (ccrp_pkg::ratio_ge(c, b, 5'd21, 5'd5) &&
                   ccrp_pkg::ratio_gt(c, g, 5'd3, 5'd1) &&
                   ccrp_pkg::ratio_le(c, g, 5'd4, 5'd1)) begin
         sample_color = 3'd5;
      end else if (ccrp_pkg::ratio_gt(c, r, 5'd7, 5'd2) &&
                   ccrp_pkg::ratio_le(c, g, 5'd14, 5'd5)) begin
         sample_color = 3'd6;
      end else if (ccrp_pkg::ratio_ge(c, g, 5'd4, 5'd1)) begin
         sample_color = 3'd7;
      end else begin
         sample_match = 1'b0;
      end
   end

   // drive magnitudes for both directions, saturated
   always_comb begin
      ccrp_pkg::color_type color_now;
      color_now = sample_match ? sample_color : current_color_ff;
      diff_up   = target_color_ff - color_now;
      diff_down = color_now - target_color_ff;
      mag_sel_up   = (slow_only_ff || diff_up <= 3'd1) ? slow_speed_ff : fast_speed_ff;
      mag_sel_down = (slow_only_ff || diff_down <= 3'd1) ? slow_speed_ff : fast_speed_ff;
      mag_up   = (mag_sel_up > ccrp_pkg::SpeedLimit) ? ccrp_pkg::SpeedLimit : mag_sel_up;
      mag_down = (mag_sel_down > ccrp_pkg::SpeedLimit) ? ccrp_pkg::SpeedLimit
                                                        : mag_sel_down;
   end

   always_comb begin
      current_color_in = current_color_ff;
      target_color_in  = target_color_ff;
      phase_in         = phase_ff;
      slow_only_in     = slow_only_ff;
      drive_in         = drive_ff;
      unique case (ccrp_pkg::op_type'(s1_operation_ff))
         ccrp_pkg::OP_COMMAND: begin
            if (!busy) begin
               if (s1_command_ff == ccrp_pkg::CmdCenter) begin
                  target_color_in = ccrp_pkg::ColorCenter;
                  slow_only_in    = 1'b0;
                  phase_in        = PHASE_UP;
                  drive_in        = '0;
               end else if (s1_command_ff >= ccrp_pkg::CmdColorLow &&
                            s1_command_ff <= ccrp_pkg::CmdColorHigh) begin
                  target_color_in = s1_command_ff[2:0];
                  slow_only_in    = 1'b0;
                  phase_in        = PHASE_UP;
                  drive_in        = '0;
               end
            end
         end
         ccrp_pkg::OP_SAMPLE: begin
            if (sample_match) current_color_in = sample_color;
            if (phase_ff == PHASE_UP && current_color_in < target_color_ff) begin
               drive_in = ccrp_pkg::drive_type'({1'b0, mag_up});
            end else if (phase_ff != PHASE_IDLE &&
                         current_color_in > target_color_ff) begin
               phase_in = PHASE_DOWN;
               drive_in = -ccrp_pkg::drive_type'({1'b0, mag_down});
            end else begin
               phase_in = PHASE_IDLE;
               drive_in = '0;
            end
         end
         ccrp_pkg::OP_CENTER: begin
            if (!busy) begin
               current_color_in = '0;
               target_color_in  = ccrp_pkg::ColorCenter;
               slow_only_in     = 1'b1;
               phase_in         = PHASE_UP;
               drive_in         = '0;
            end
         end
         ccrp_pkg::OP_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_speed_ff    <= ccrp_pkg::SlowReset;
         fast_speed_ff    <= ccrp_pkg::FastReset;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         current_color_ff <= '0;
         target_color_ff  <= '0;
         phase_ff         <= PHASE_IDLE;
         slow_only_ff     <= 1'b0;
         drive_ff         <= '0;
      end else begin
         if (csr_valid) begin
            unique case (ccrp_pkg::csr_index_type'(csr_index))
               ccrp_pkg::CSR_SLOW_SPEED: slow_speed_ff <= csr_data;
               ccrp_pkg::CSR_FAST_SPEED: fast_speed_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= s1_valid_ff;
         if (advance && s1_valid_ff) begin
            current_color_ff <= current_color_in;
            target_color_ff  <= target_color_in;
            phase_ff         <= phase_in;
            slow_only_ff     <= slow_only_in;
            drive_ff         <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_operation_ff <= req_operation;
         s1_command_ff   <= req_command_byte;
         s1_clear_ff     <= ccrp_pkg::count_type'(req_clear_count);
         s1_red_ff       <= ccrp_pkg::count_type'(req_red_count);
         s1_green_ff     <= ccrp_pkg::count_type'(req_green_count);
         s1_blue_ff      <= ccrp_pkg::count_type'(req_blue_count);
      end
      if (advance && s1_valid_ff) begin
         rsp_motor_speed_ff <= drive_in;
         rsp_color_code_ff  <= current_color_in;
         rsp_busy_res_ff    <= (phase_in != PHASE_IDLE);
      end
   end

endmodule

/* design/ccrp_checker.sv */
// ----------------------------------------------------------------------------
// ccrp_checker
// Port-level checks for the rudder positioner, bound to the top level.
// ----------------------------------------------------------------------------
module ccrp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [9:0]  rsp_motor_speed,
   input logic [2:0]         rsp_color_code,
   input logic               rsp_busy_res
);

   // hold a stalled result
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_motor_speed) &&
                                     $stable(rsp_color_code) && $stable(rsp_busy_res);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   property p_idle_stopped;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_busy_res |-> rsp_motor_speed == 10'sd0;
   endproperty
   a_idle_stopped: assert property (p_idle_stopped) else $error("drive while idle");

   property p_drive_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_motor_speed <= $signed({1'b0, ccrp_pkg::SpeedLimit}) &&
                       rsp_motor_speed >= -$signed({1'b0, ccrp_pkg::SpeedLimit});
   endproperty
   a_drive_range: assert property (p_drive_range) else $error("drive out of range");

   property p_ready_when_empty;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> req_ready;
   endproperty
   a_ready_when_empty: assert property (p_ready_when_empty)
      else $error("input stalled with empty output");

endmodule

bind color_coded_rudder_positioner ccrp_checker u_ccrp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_motor_speed (rsp_motor_speed),
   .rsp_color_code  (rsp_color_code),
   .rsp_busy_res    (rsp_busy_res)
);
